[hw/rtl/sliding_median_filter_assert.svh]
// Assertion macros used by the median filter module.
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("median filter assertion failed");
// Condition a implies condition b in the following cycle.
`define SMF_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("median filter assertion failed");
`else
`define SMF_ASSERT(lbl, prop)
`define SMF_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[hw/rtl/smf_pkg.sv]
package smf_pkg;

  // Width of one sample and of the median.
  localparam int unsigned SampleW = 16;

  // Default window length and rank.
  localparam int unsigned WindowDef = 15;
  localparam int unsigned RankDef   = 8;

  typedef logic [SampleW-1:0] sample_t;

endpackage

[hw/rtl/smf_cell.sv]
module smf_cell #(
  parameter int unsigned Window = 15,
  parameter int unsigned Index  = 0,
  parameter int unsigned AgeW   = $clog2(Window)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  smf_pkg::sample_t    sample_i,
  input  smf_pkg::sample_t    left_val_i,
  input  logic [AgeW-1:0]     left_age_i,
  input  smf_pkg::sample_t    right_val_i,
  input  logic [AgeW-1:0]     right_age_i,
  input  logic                old_seen_i,
  output logic                old_seen_o,
  output logic                old_o,
  output smf_pkg::sample_t    val_o,
  output logic [AgeW-1:0]     age_o,
  output smf_pkg::sample_t    val_d_o
);
  import smf_pkg::*;

  localparam logic [AgeW-1:0] OldestAge = AgeW'(Window - 1);
  localparam logic [AgeW-1:0] ResetAge  = AgeW'(Index);
  localparam bit              IsFirst   = (Index == 0);
  localparam bit              IsLast    = (Index == Window - 1);

  sample_t         val_q, val_d;
  logic [AgeW-1:0] age_q, age_d;
  logic            here;
  sample_t         low_val, own_val;
  logic [AgeW-1:0] low_age, own_age;

  // This cell holds the oldest entry, which leaves the window on this item.
  assign old_o      = (age_q == OldestAge);
  assign here       = old_seen_i | old_o;
  assign old_seen_o = here;

  // Entries of the window after the oldest one is removed: the one that lands
  // just below this slot and the one that lands in this slot.
  assign low_val = old_seen_i ? val_q : left_val_i;
  assign low_age = old_seen_i ? age_q : left_age_i;
  assign own_val = here ? right_val_i : val_q;
  assign own_age = here ? right_age_i : age_q;

  // Insert the new sample into the shortened sorted row.
  always_comb begin
    if (!IsFirst && (low_val > sample_i)) begin
      val_d = low_val;
      age_d = low_age + AgeW'(1);
    end else if (!IsLast && !(own_val > sample_i)) begin
      val_d = own_val;
      age_d = own_age + AgeW'(1);
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  // Reset fills the window with zeros of distinct ages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= ResetAge;
    end else if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o   = val_q;
  assign age_o   = age_q;
  assign val_d_o = val_d;

endmodule

[hw/rtl/sliding_median_filter.sv]
// Channel   Direction  Signals                                     Payload
// sample    in         sample_valid_i / sample_ready_o             sample_i (16 bit)
// median    out        median_valid_o / median_ready_i             median_o (16 bit)
//
// One item per cycle unless the median output stalls; the median of an item appears in the cycle after it is taken.
// The window is a sorted row of WINDOW cells; each item removes the oldest
// entry and inserts the new sample in one pass along the row.
// Reset fills the window with zeros, which count as samples.
// A result register holds the median; while it waits, a new item is taken
// only in the cycle in which the waiting result is taken.
module sliding_median_filter #(
  parameter int unsigned WINDOW = smf_pkg::WindowDef,
  parameter int unsigned RANK   = smf_pkg::RankDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sample_valid_i,
  output logic             sample_ready_o,
  input  smf_pkg::sample_t sample_i,
  output logic             median_valid_o,
  input  logic             median_ready_i,
  output smf_pkg::sample_t median_o
);
  import smf_pkg::*;

  `include "sliding_median_filter_assert.svh"

  localparam int unsigned AgeW    = $clog2(WINDOW);
  localparam int unsigned RankEff = (RANK < 1) ? 1 : ((RANK > WINDOW) ? WINDOW : RANK);

  sample_t         val_w   [WINDOW];
  sample_t         val_d_w [WINDOW];
  logic [AgeW-1:0] age_w   [WINDOW];
  logic [WINDOW:0] seen_w;
  logic [WINDOW-1:0] old_w;
  logic [WINDOW-2:0] asc_w;
  logic            accept;
  logic            out_valid_q;
  sample_t         median_q;

  assign accept         = sample_valid_i & sample_ready_o;
  assign sample_ready_o = !out_valid_q | median_ready_i;
  assign seen_w[0]      = 1'b0;

  // Sorted row of window cells.
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    smf_cell #(
      .Window (WINDOW),
      .Index  (k),
      .AgeW   (AgeW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .sample_i    (sample_i),
      .left_val_i  ((k == 0) ? '0 : val_w[(k == 0) ? 0 : k - 1]),
      .left_age_i  ((k == 0) ? '0 : age_w[(k == 0) ? 0 : k - 1]),
      .right_val_i ((k == WINDOW - 1) ? '0 : val_w[(k == WINDOW - 1) ? k : k + 1]),
      .right_age_i ((k == WINDOW - 1) ? '0 : age_w[(k == WINDOW - 1) ? k : k + 1]),
      .old_seen_i  (seen_w[k]),
      .old_seen_o  (seen_w[k+1]),
      .old_o       (old_w[k]),
      .val_o       (val_w[k]),
      .age_o       (age_w[k]),
      .val_d_o     (val_d_w[k])
    );
  end

  // Ordering check of neighboring cells.
  for (genvar k = 0; k < WINDOW - 1; k++) begin : g_asc
    assign asc_w[k] = (val_w[k] <= val_w[k+1]);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (median_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= val_d_w[RankEff-1];
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_o       = median_q;

  `SMF_ASSERT(a_one_oldest, $onehot(old_w) && !seen_w[0] && seen_w[WINDOW])
  `SMF_ASSERT(a_row_sorted, &asc_w)
  `SMF_ASSERT_NEXT(a_result_after_item, accept, out_valid_q && (median_q == val_w[RankEff-1]))

endmodule
